// ===== design/mpf_pkg.sv =====
// Shared constants, codes and the controller-to-datapath command bundle.
package mpf_pkg;

    localparam int MAX_LEVELS_DEF = 8;
    localparam int CAPACITY_DEF   = 64;
    localparam int ID_BITS_DEF    = 16;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADLVL = 2'd3;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

// ===== design/mpf_ctrl.sv =====
// Request sequencer: capture cycle, then commit cycle gated by the output register.
module mpf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output mpf_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (cmd.commit)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/mpf_datapath.sv =====
// Level pointers, linked entry store, free stack and result register.
module mpf_datapath #(
    parameter int MAX_LEVELS = mpf_pkg::MAX_LEVELS_DEF,
    parameter int CAPACITY   = mpf_pkg::CAPACITY_DEF,
    parameter int ID_BITS    = mpf_pkg::ID_BITS_DEF,
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int NL_W      = $clog2(MAX_LEVELS + 1),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpf_pkg::cmd_t      cmd,
    input  logic               cfg_we,
    input  logic [NL_W-1:0]    cfg_wdata,
    input  logic [1:0]         action,
    input  logic [LVL_W-1:0]   priority_req,
    input  logic [ID_BITS-1:0] task_id,
    output logic [1:0]         status,
    output logic [ID_BITS-1:0] popped_id,
    output logic [CNT_W-1:0]   total_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = NL_W + LVL_W;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } op_t;

    logic [NL_W-1:0]       num_levels_reg;
    logic [ADDR_W-1:0]     head_ptr_reg [MAX_LEVELS];
    logic [ADDR_W-1:0]     tail_ptr_reg [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] nonempty_reg;
    // free_head doubles as the queued total; hw marks free-stack slots never rewritten
    logic [CNT_W-1:0]      free_head_reg;
    logic [CNT_W-1:0]      free_head_next;
    logic [CNT_W-1:0]      hw_reg;

    logic [ID_BITS-1:0]    id_mem   [CAPACITY];
    logic [ADDR_W-1:0]     link_mem [CAPACITY];
    logic [ADDR_W-1:0]     free_mem [CAPACITY];

    op_t                   op_reg;
    logic [1:0]            st_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic                  fresh_reg;
    logic [ID_BITS-1:0]    id_rd_reg;
    logic [ADDR_W-1:0]     link_rd_reg;
    logic [ADDR_W-1:0]     free_rd_reg;

    logic [1:0]            status_reg;
    logic [ID_BITS-1:0]    popped_id_reg;
    logic [CNT_W-1:0]      total_count_reg;

    logic [NL_W-1:0]       lvl_use;
    logic                  lvl_ok;
    logic                  lvl_ne;
    logic                  full;
    logic [ADDR_W-1:0]     head_sel;
    op_t                   op_dec;
    logic [1:0]            st_dec;

    logic [ADDR_W-1:0]     push_entry;
    logic [ADDR_W-1:0]     pop_entry;
    logic [CNT_W-1:0]      fh_dec;

    // Level count register: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (num_levels_reg == '0)
            lvl_use = NL_W'(1);
        else if (num_levels_reg > NL_W'(MAX_LEVELS))
            lvl_use = NL_W'(MAX_LEVELS);
        else
            lvl_use = num_levels_reg;
    end

    assign lvl_ok   = CMP_W'(priority_req) < CMP_W'(lvl_use);
    assign lvl_ne   = lvl_ok ? nonempty_reg[priority_req] : 1'b0;
    assign head_sel = lvl_ok ? head_ptr_reg[priority_req] : '0;
    assign full     = (free_head_reg == CNT_W'(CAPACITY));

    // Decode of an incoming request; bad level is checked before full store
    always_comb
    begin
        op_dec = OP_NONE;
        st_dec = mpf_pkg::ST_OK;
        case (action)
            mpf_pkg::ACT_PUSH:
            begin
                if (!lvl_ok)
                    st_dec = mpf_pkg::ST_BADLVL;
                else if (full)
                    st_dec = mpf_pkg::ST_FULL;
                else
                    op_dec = OP_PUSH;
            end
            mpf_pkg::ACT_POP:
            begin
                if (!lvl_ok)
                    st_dec = mpf_pkg::ST_BADLVL;
                else if (!lvl_ne)
                    st_dec = mpf_pkg::ST_EMPTY;
                else
                    op_dec = OP_POP;
            end
            mpf_pkg::ACT_CLEAR: op_dec = OP_CLEAR;
            default: op_dec = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_NONE;
        else if (cmd.capture)
            op_reg <= op_dec;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            st_reg    <= st_dec;
            lvl_reg   <= priority_req;
            id_reg    <= task_id;
            fresh_reg <= (free_head_reg == hw_reg);
        end
    end

    // Slots at or above the high-water mark still hold their own index
    assign push_entry = fresh_reg ? free_head_reg[ADDR_W-1:0] : free_rd_reg;
    assign pop_entry  = head_ptr_reg[lvl_reg];
    assign fh_dec     = free_head_reg - CNT_W'(1);

    always_comb
    begin
        case (op_reg)
            OP_PUSH:  free_head_next = free_head_reg + CNT_W'(1);
            OP_POP:   free_head_next = fh_dec;
            OP_CLEAR: free_head_next = '0;
            default:  free_head_next = free_head_reg;
        endcase
    end

    // Entry store: read at capture, written at commit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_rd_reg   <= id_mem[head_sel];
            link_rd_reg <= link_mem[head_sel];
            free_rd_reg <= free_mem[free_head_reg[ADDR_W-1:0]];
        end
        if (cmd.commit && (op_reg == OP_PUSH))
            id_mem[push_entry] <= id_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_PUSH) && nonempty_reg[lvl_reg])
            link_mem[tail_ptr_reg[lvl_reg]] <= push_entry;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_POP))
            free_mem[fh_dec[ADDR_W-1:0]] <= pop_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_levels_reg <= NL_W'(MAX_LEVELS);
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            hw_reg         <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_ptr_reg[i] <= '0;
                tail_ptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                num_levels_reg <= cfg_wdata;
            if (cmd.commit)
            begin
                free_head_reg <= free_head_next;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (!nonempty_reg[lvl_reg])
                        begin
                            head_ptr_reg[lvl_reg] <= push_entry;
                            nonempty_reg[lvl_reg] <= 1'b1;
                        end
                        tail_ptr_reg[lvl_reg] <= push_entry;
                        if (fresh_reg)
                            hw_reg <= hw_reg + CNT_W'(1);
                    end
                    OP_POP:
                    begin
                        if (pop_entry == tail_ptr_reg[lvl_reg])
                        begin
                            nonempty_reg[lvl_reg] <= 1'b0;
                            head_ptr_reg[lvl_reg] <= '0;
                            tail_ptr_reg[lvl_reg] <= '0;
                        end
                        else
                            head_ptr_reg[lvl_reg] <= link_rd_reg;
                    end
                    OP_CLEAR:
                    begin
                        nonempty_reg <= '0;
                        hw_reg       <= '0;
                        for (int i = 0; i < MAX_LEVELS; i++)
                        begin
                            head_ptr_reg[i] <= '0;
                            tail_ptr_reg[i] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg      <= st_reg;
            popped_id_reg   <= (op_reg == OP_POP) ? id_rd_reg : '0;
            total_count_reg <= free_head_next;
        end
    end

    assign status      = status_reg;
    assign popped_id   = popped_id_reg;
    assign total_count = total_count_reg;

endmodule

// ===== design/multilevel_priority_fifo.sv =====
// Each request has a capture and a commit step: the accept edge registers the decode and
// issues the single read of the entry, link and free-stack memories, and the commit edge
// updates the pointers and makes the one write per memory. The result then waits in an
// output register; the block takes the next request meanwhile, but that request commits
// only once the earlier result is taken. A clear commits like any request: the free stack
// uses a high-water mark, not a rebuild sweep, and reset needs no clearing pass. The user
// must write levels via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module multilevel_priority_fifo #(
    parameter int MAX_LEVELS = mpf_pkg::MAX_LEVELS_DEF,
    parameter int CAPACITY   = mpf_pkg::CAPACITY_DEF,
    parameter int ID_BITS    = mpf_pkg::ID_BITS_DEF,
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int NL_W      = $clog2(MAX_LEVELS + 1),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [NL_W-1:0]    cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [LVL_W-1:0]   priority_req,
    input  logic [ID_BITS-1:0] task_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [ID_BITS-1:0] popped_id,
    output logic [CNT_W-1:0]   total_count
);

    mpf_pkg::cmd_t cmd;

    mpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mpf_datapath #(
        .MAX_LEVELS (MAX_LEVELS),
        .CAPACITY   (CAPACITY),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .priority_req (priority_req),
        .task_id      (task_id),
        .status       (status),
        .popped_id    (popped_id),
        .total_count  (total_count)
    );

endmodule

// ===== design/mpf_checker.sv =====
// Port-level checks for the priority FIFO, bound to the top level.
module mpf_port_props #(
    parameter int CAPACITY = mpf_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = mpf_pkg::ID_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic [ID_BITS-1:0] popped_id,
    input logic [CNT_W-1:0]   total_count
);

    // A held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(popped_id) && $stable(total_count))
        else $error("result changed while stalled");

    // One request in flight: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted during execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != mpf_pkg::ST_OK) |-> (popped_id == '0))
        else $error("popped id on failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mpf_pkg::ST_FULL) |-> (total_count == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_count <= CNT_W'(CAPACITY)))
        else $error("total count above capacity");

endmodule

bind multilevel_priority_fifo mpf_port_props #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
) u_mpf_port_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .popped_id   (popped_id),
    .total_count (total_count)
);

// ===== tb/mpf_checker.sv =====
// Reply checker for the multilevel priority FIFO: tracks the queues and compares every reply.
module mpf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  priority_req,
    input  logic [15:0] task_id,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] popped_id,
    input  logic [6:0]  total_count,
    output int          mismatch_count,
    output int          replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS  = mpf_pkg::MAX_LEVELS_DEF;
    localparam int ENTRIES = mpf_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_id;
        logic [6:0]  total_count;
    } reply_t;

    reply_t      predicted_replies[$];

    logic [3:0]  levels_reg;
    logic [5:0]  level_head [LEVELS];
    logic [5:0]  level_tail [LEVELS];
    logic [7:0]  level_busy;
    logic [5:0]  link_mem [ENTRIES];
    logic [15:0] id_mem [ENTRIES];
    logic [5:0]  free_stack [ENTRIES];
    logic [6:0]  used_entries;
    logic [6:0]  queued;

    function automatic void empty_levels();
        for (int i = 0; i < LEVELS; i++)
        begin
            level_head[i] = '0;
            level_tail[i] = '0;
        end
        for (int i = 0; i < ENTRIES; i++)
            free_stack[i] = 6'(i);
        level_busy   = '0;
        used_entries = '0;
        queued       = '0;
    endfunction

    // Applies one request to the tracked queues and returns the reply it should give.
    function automatic reply_t apply_request(input logic [1:0] act, input logic [2:0] lvl,
                                             input logic [15:0] id);
        reply_t      r;
        int unsigned active;
        logic [5:0]  e;
        r.status      = mpf_pkg::ST_OK;
        r.popped_id   = '0;
        active        = levels_reg;
        if (active < 1)
            active = 1;
        if (active > LEVELS)
            active = LEVELS;
        if (act == mpf_pkg::ACT_PUSH || act == mpf_pkg::ACT_POP)
        begin
            if (lvl >= active)
                r.status = mpf_pkg::ST_BADLVL;
            else if (act == mpf_pkg::ACT_PUSH)
            begin
                if (used_entries >= ENTRIES)
                    r.status = mpf_pkg::ST_FULL;
                else
                begin
                    e = free_stack[used_entries[5:0]];
                    used_entries++;
                    id_mem[e]   = id;
                    link_mem[e] = '0;
                    if (level_busy[lvl])
                        link_mem[level_tail[lvl]] = e;
                    else
                    begin
                        level_head[lvl] = e;
                        level_busy[lvl] = 1'b1;
                    end
                    level_tail[lvl] = e;
                    queued++;
                end
            end
            else if (!level_busy[lvl])
                r.status = mpf_pkg::ST_EMPTY;
            else
            begin
                e = level_head[lvl];
                r.popped_id = id_mem[e];
                if (e == level_tail[lvl])
                begin
                    level_busy[lvl] = 1'b0;
                    level_head[lvl] = '0;
                    level_tail[lvl] = '0;
                end
                else
                    level_head[lvl] = link_mem[e];
                if (used_entries > 0)
                begin
                    used_entries--;
                    free_stack[used_entries[5:0]] = e;
                end
                if (queued > 0)
                    queued--;
            end
        end
        else if (act == mpf_pkg::ACT_CLEAR)
            empty_levels();
        r.total_count = queued;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t MISMATCH %s: got %0d, predicted %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            levels_reg = 4'd8;
            for (int i = 0; i < ENTRIES; i++)
            begin
                link_mem[i] = '0;
                id_mem[i]   = '0;
            end
            empty_levels();
            predicted_replies.delete();
            mismatch_count = 0;
            replies_due    = 0;
        end
        else
        begin
            if (cfg_we)
                levels_reg = cfg_wdata;
            // a reply can never leave on the edge its own request enters, so push first
            if (in_valid && in_ready)
                predicted_replies.push_back(apply_request(action, priority_req, task_id));
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                    report_mismatch("reply with no request pending", status, 0);
                else
                begin
                    want = predicted_replies.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (popped_id !== want.popped_id)
                        report_mismatch("popped_id", popped_id, want.popped_id);
                    if (total_count !== want.total_count)
                        report_mismatch("total_count", total_count, want.total_count);
                end
            end
            replies_due = predicted_replies.size();
        end
    end

endmodule

// ===== tb/tb_multilevel_priority_fifo.sv =====
// Testbench top for the multilevel priority FIFO: stimulus, flow control and verdict.
module tb_multilevel_priority_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS    = 175;
    // level register per random phase, phase 0 in the low nibble
    localparam logic [31:0] PHASE_LEVELS   = {4'd8, 4'd2, 4'd15, 4'd5,
                                              4'd0, 4'd8, 4'd3, 4'd1};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [2:0]  priority_req;
    logic [15:0] task_id;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] popped_id;
    logic [6:0]  total_count;

    int          mismatch_count;
    int          replies_due;
    int          cur_levels;
    int          tx_idle_pct;
    int          rx_stall_pct;
    logic        rx_hold_pending;
    int          rx_hold_left;
    int          quiet_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    multilevel_priority_fifo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .priority_req (priority_req),
        .task_id      (task_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_id    (popped_id),
        .total_count  (total_count)
    );

    mpf_checker reply_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .priority_req   (priority_req),
        .task_id        (task_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .popped_id      (popped_id),
        .total_count    (total_count),
        .mismatch_count (mismatch_count),
        .replies_due    (replies_due)
    );

    // Reply side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        out_ready    = 1'b0;
        rx_hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_pending)
            begin
                rx_hold_pending = 1'b0;
                rx_hold_left    = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic offer_request(input logic [1:0] act, input logic [2:0] lvl,
                                 input logic [15:0] id);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        priority_req <= lvl;
        task_id      <= id;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Level count may only change with nothing in flight.
    task automatic write_levels(input logic [3:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_levels = (value == 0) ? 1 : (value > 8) ? 8 : value;
    endtask

    // Push-heavy first half fills the store, pop-heavy second half drains it.
    task automatic run_mix(input int count);
        int         push_pct;
        int         pick;
        logic [2:0] lvl;
        for (int i = 0; i < count; i++)
        begin
            push_pct = (i < count / 2) ? 70 : 30;
            pick     = $urandom_range(99);
            if ($urandom_range(9) == 0)
                lvl = 3'($urandom_range(7));
            else
                lvl = 3'($urandom_range(cur_levels - 1));
            if (pick < 2)
                offer_request(mpf_pkg::ACT_CLEAR, lvl, 16'($urandom));
            else if (pick < 3)
                offer_request(ACT_UNUSED, lvl, 16'($urandom));
            else if ($urandom_range(99) < push_pct)
                offer_request(mpf_pkg::ACT_PUSH, lvl, 16'($urandom));
            else
                offer_request(mpf_pkg::ACT_POP, lvl, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        action          = mpf_pkg::ACT_PUSH;
        priority_req    = '0;
        task_id         = '0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        cur_levels      = 8;
        rx_hold_pending = 1'b0;
        quiet_cycles    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer_request(mpf_pkg::ACT_POP, 3'd0, 16'h0000);     // empty level
        offer_request(mpf_pkg::ACT_PUSH, 3'd0, 16'h0000);
        offer_request(mpf_pkg::ACT_PUSH, 3'd0, 16'hFFFF);
        offer_request(mpf_pkg::ACT_PUSH, 3'd7, 16'hA5A5);
        offer_request(mpf_pkg::ACT_PUSH, 3'd3, 16'h5A5A);
        offer_request(mpf_pkg::ACT_POP, 3'd0, 16'hFFFF);     // id ignored on pop
        offer_request(mpf_pkg::ACT_POP, 3'd7, 16'h0000);
        offer_request(ACT_UNUSED, 3'd7, 16'hFFFF);
        write_levels(4'd2);
        offer_request(mpf_pkg::ACT_PUSH, 3'd2, 16'h0001);    // bad level
        offer_request(mpf_pkg::ACT_POP, 3'd3, 16'h0000);     // stranded level, still counted
        offer_request(mpf_pkg::ACT_POP, 3'd1, 16'h0000);
        write_levels(4'd0);                                  // acts as one level
        offer_request(mpf_pkg::ACT_PUSH, 3'd1, 16'h0002);
        offer_request(mpf_pkg::ACT_PUSH, 3'd0, 16'h0003);
        offer_request(mpf_pkg::ACT_POP, 3'd0, 16'h0000);
        write_levels(4'd15);                                 // clamps to the maximum
        offer_request(mpf_pkg::ACT_POP, 3'd3, 16'h0000);
        offer_request(mpf_pkg::ACT_POP, 3'd0, 16'h0000);
        offer_request(mpf_pkg::ACT_PUSH, 3'd5, 16'h1234);
        offer_request(mpf_pkg::ACT_CLEAR, 3'd5, 16'h0000);
        offer_request(mpf_pkg::ACT_POP, 3'd5, 16'h0000);

        // back-pressure: replies held off while pushes pile up past a full store
        write_levels(4'd8);
        for (int i = 0; i < 80; i++)
        begin
            offer_request(mpf_pkg::ACT_PUSH, 3'($urandom_range(7)), 16'($urandom));
            if (i == 0)
                rx_hold_pending = 1'b1;
        end

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
            endcase
            write_levels(PHASE_LEVELS[4*p +: 4]);
            run_mix(PHASE_ITEMS);
        end

        rx_stall_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/mpf_pkg.sv
design/mpf_ctrl.sv
design/mpf_datapath.sv
design/multilevel_priority_fifo.sv
design/mpf_checker.sv
tb/mpf_checker.sv
tb/tb_multilevel_priority_fifo.sv
